// ----- rtl/hje_pkg.sv -----
`default_nettype none

package hje_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] ChrBs     = 8'h08;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrLf     = 8'h0A;
  localparam logic [7:0] ChrFf     = 8'h0C;
  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrQuote  = 8'h22;
  localparam logic [7:0] ChrApos   = 8'h27;
  localparam logic [7:0] ChrComma  = 8'h2C;
  localparam logic [7:0] ChrColon  = 8'h3A;
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrLowB   = 8'h62;
  localparam logic [7:0] ChrLowF   = 8'h66;
  localparam logic [7:0] ChrLowT   = 8'h74;

  localparam int unsigned IdxW = 3;

  typedef enum logic [1:0] {
    CmdChar,
    CmdEsc,
    CmdSepName,
    CmdSepValue
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       json;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [IdxW-1:0] cmd_last_idx(input cmd_t cmd);
    logic [IdxW-1:0] r;
    case (cmd.kind)
      CmdChar:     r = IdxW'(0);
      CmdEsc:      r = IdxW'(1);
      CmdSepName,
      CmdSepValue: r = cmd.json ? IdxW'(2) : IdxW'(4);
      default:     r = IdxW'(0);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t cmd, input logic [IdxW-1:0] idx);
    logic [7:0] q;
    logic [7:0] r;
    q = cmd.json ? ChrQuote : ChrApos;
    r = cmd.ch;
    case (cmd.kind)
      CmdChar: r = cmd.ch;
      CmdEsc:  r = (idx == IdxW'(0)) ? ChrBslash : cmd.ch;
      CmdSepName: begin
        if (cmd.json) begin
          r = (idx == IdxW'(1)) ? ChrColon : ChrQuote;
        end else begin
          case (idx)
            IdxW'(1), IdxW'(3): r = ChrSpace;
            IdxW'(2):           r = ChrColon;
            default:            r = q;
          endcase
        end
      end
      CmdSepValue: begin
        if (cmd.json) begin
          r = (idx == IdxW'(1)) ? ChrComma : ChrQuote;
        end else begin
          case (idx)
            IdxW'(1): r = ChrComma;
            IdxW'(2): r = ChrLf;
            IdxW'(3): r = ChrTab;
            default:  r = q;
          endcase
        end
      end
      default: r = cmd.ch;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hje_front.sv -----
`default_nettype none

module hje_front
  import hje_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] in_char_i,
  input  wire        json_mode_i,
  input  wire        q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    PhBeforeName,
    PhInName,
    PhBeforeValue,
    PhInValue
  } phase_e;

  phase_e phase_q, phase_d;
  logic   emit;
  logic   blank;
  logic   accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign blank      = (in_char_i == ChrSpace) || (in_char_i == ChrTab);

  always_comb begin
    phase_d       = phase_q;
    emit          = 1'b0;
    cmd_o.kind    = CmdChar;
    cmd_o.json    = json_mode_i;
    cmd_o.ch      = in_char_i;
    if (phase_q != PhInValue && blank) begin
      emit = 1'b0;
    end else if (phase_q == PhInName && in_char_i == ChrColon) begin
      emit       = 1'b1;
      cmd_o.kind = CmdSepName;
      phase_d    = PhBeforeValue;
    end else if (in_char_i == ChrCr) begin
      emit = 1'b0;
    end else if (in_char_i == ChrLf) begin
      if (phase_q != PhBeforeName) begin
        emit       = 1'b1;
        cmd_o.kind = CmdSepValue;
        phase_d    = PhBeforeName;
      end
    end else begin
      emit = 1'b1;
      case (phase_q)
        PhBeforeName:  phase_d = PhInName;
        PhBeforeValue: phase_d = PhInValue;
        default:       phase_d = phase_q;
      endcase
      case (in_char_i)
        ChrQuote: begin
          cmd_o.kind = CmdEsc;
          cmd_o.ch   = ChrQuote;
        end
        ChrBslash: begin
          cmd_o.kind = CmdEsc;
          cmd_o.ch   = ChrBslash;
        end
        ChrBs: begin
          cmd_o.kind = CmdEsc;
          cmd_o.ch   = ChrLowB;
        end
        ChrFf: begin
          cmd_o.kind = CmdEsc;
          cmd_o.ch   = ChrLowF;
        end
        ChrTab: begin
          cmd_o.kind = CmdEsc;
          cmd_o.ch   = ChrLowT;
        end
        default: cmd_o.kind = CmdChar;
      endcase
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBeforeName;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hje_queue.sv -----
`default_nettype none

module hje_queue
  import hje_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  wire cmd_t  cmd_i,
  output logic       full_o,
  input  wire        pop_i,
  output logic       empty_o,
  output cmd_t       cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == CntW'(0));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? PtrW'(0) : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? PtrW'(0) : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hje_back.sv -----
`default_nettype none

module hje_back
  import hje_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        q_empty_i,
  input  wire cmd_t  q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);

  logic            cur_valid_q, cur_valid_d;
  cmd_t            cur_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            fire;
  logic            done;
  logic            load;

  assign out_valid_o   = cur_valid_q;
  assign out_char_o    = cmd_byte(cur_q, idx_q);
  assign last_of_run_o = (idx_q == cmd_last_idx(cur_q));

  assign fire  = cur_valid_q && out_ready_i;
  assign done  = fire && last_of_run_o;
  assign load  = (!cur_valid_q || done) && !q_empty_i;
  assign pop_o = load;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end else if (done) begin
      cur_valid_d = 1'b0;
      idx_d       = '0;
    end else if (fire) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/header_text_json_escaper_top.sv -----
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    in_char_i
// out       output     out_valid_o / out_ready_i  out_char_o, last_of_run_o
// apb       input      psel/penable/pwrite        paddr, pwdata -> prdata
//
// One input word is taken per cycle while the command queue has room.
// Each word expands to 0..5 output words from the back-end register, one per cycle
// while out_ready_i is high.
// Reset clears the parse phase, the queue and the mode register (pretty mode).
// Output stalls fill the queue; input stalls only once it is full.

`default_nettype none

module header_text_json_escaper_top
  import hje_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  in_char_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_of_run_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic json_mode_q;
  logic cfg_wr;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t front_cmd;
  cmd_t q_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, json_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      json_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      json_mode_q <= pwdata[0];
    end
  end

  hje_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char_i),
    .json_mode_i (json_mode_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  hje_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  hje_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_cmd_i       (q_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_char_o    (out_char_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

// ----- verif/hje_escape_checker.sv -----
`timescale 1ns / 1ps

module hje_escape_checker
  import hje_pkg::*;
#(
  parameter logic [2:0] ModeAddr = 3'd0
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [7:0]  in_char_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [7:0]  out_char_i,
  input  wire         last_of_run_i,
  input  wire         psel_i,
  input  wire         penable_i,
  input  wire         pwrite_i,
  input  wire  [2:0]  paddr_i,
  input  wire  [31:0] pwdata_i,
  input  wire  [31:0] prdata_i,
  input  wire         pready_i,
  output int unsigned pending_o,
  output int unsigned fail_cnt_o
);

  typedef enum logic [1:0] {
    PhBeforeName,
    PhInName,
    PhBeforeValue,
    PhInValue
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  // separators, first byte in the top bits
  localparam logic [39:0] NameSepJson    = {ChrQuote, ChrColon, ChrQuote, 16'h0};
  localparam logic [39:0] NameSepPretty  = {ChrApos, ChrSpace, ChrColon, ChrSpace, ChrApos};
  localparam logic [39:0] ValueSepJson   = {ChrQuote, ChrComma, ChrQuote, 16'h0};
  localparam logic [39:0] ValueSepPretty = {ChrApos, ChrComma, ChrLf, ChrTab, ChrApos};

  phase_e      phase;
  logic        json_mode;
  out_word_t   escaped_q [$];
  out_word_t   want;
  int unsigned fails;

  task automatic push_run(input logic [39:0] run, input int n);
    for (int k = 0; k < n; k++) begin
      escaped_q.push_back(out_word_t'{ch: run[39-8*k -: 8], last: (k == n - 1)});
    end
  endtask

  task automatic escape_header_byte(input logic [7:0] c);
    if (phase != PhInValue && (c == ChrSpace || c == ChrTab)) return;
    if (phase == PhInName && c == ChrColon) begin
      phase = PhBeforeValue;
      if (json_mode) push_run(NameSepJson, 3);
      else push_run(NameSepPretty, 5);
      return;
    end
    if (c == ChrCr) return;
    if (c == ChrLf) begin
      if (phase == PhBeforeName) return;
      phase = PhBeforeName;
      if (json_mode) push_run(ValueSepJson, 3);
      else push_run(ValueSepPretty, 5);
      return;
    end
    if (phase == PhBeforeName) phase = PhInName;
    else if (phase == PhBeforeValue) phase = PhInValue;
    case (c)
      ChrQuote:  push_run({ChrBslash, ChrQuote, 24'h0}, 2);
      ChrBslash: push_run({ChrBslash, ChrBslash, 24'h0}, 2);
      ChrBs:     push_run({ChrBslash, ChrLowB, 24'h0}, 2);
      ChrFf:     push_run({ChrBslash, ChrLowF, 24'h0}, 2);
      ChrTab:    push_run({ChrBslash, ChrLowT, 24'h0}, 2);
      default:   push_run({c, 32'h0}, 1);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase     = PhBeforeName;
      json_mode = 1'b0;
      fails     = 0;
      escaped_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == ModeAddr) begin
        if (pwrite_i) begin
          json_mode = pwdata_i[0];
        end else if (prdata_i !== 32'(json_mode)) begin
          $display("%0t: mode readback: expected %08h, got %08h", $time,
                   32'(json_mode), prdata_i);
          fails++;
        end
      end
      if (in_valid_i && in_ready_i) escape_header_byte(in_char_i);
      if (out_valid_i && out_ready_i) begin
        if (escaped_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got char %02h last %0b", $time,
                   out_char_i, last_of_run_i);
          fails++;
        end else begin
          want = escaped_q.pop_front();
          if (out_char_i !== want.ch || last_of_run_i !== want.last) begin
            $display("%0t: word mismatch: expected char %02h last %0b, got char %02h last %0b",
                     $time, want.ch, want.last, out_char_i, last_of_run_i);
            fails++;
          end
        end
      end
    end
    pending_o  <= escaped_q.size();
    fail_cnt_o <= fails;
  end

endmodule

// ----- verif/tb_header_text_json_escaper_top.sv -----
`timescale 1ns / 1ps

module tb_header_text_json_escaper_top;
  import hje_pkg::*;

  localparam logic [2:0]  RegModeAddr = 3'd0;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseWords  = 33;
  localparam logic [7:0]  ChrLowA     = 8'h61;
  localparam logic [7:0]  ChrLowZ     = 8'h7A;
  localparam logic [7:0]  ChrDigit0   = 8'h30;
  localparam logic [7:0]  ChrDigit9   = 8'h39;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  in_char_i   = '0;
  logic        out_ready_i = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_char_o;
  logic        last_of_run_o;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending;
  int unsigned fail_cnt;
  int unsigned words_in    = 0;
  int unsigned words_out   = 0;
  int unsigned mode_writes = 0;
  int unsigned idle_cycles = 0;
  bit          rx_eager    = 1'b0;
  bit          rx_hold_req = 1'b0;
  bit          tx_gapless  = 1'b0;

  // pretty-mode part, then json-mode part
  logic [7:0] pretty_text [$] = '{ChrSpace, ChrTab, ChrCr, ChrLf, ChrColon, 8'h00, ChrQuote,
                                  ChrColon, ChrSpace, ChrTab, ChrColon, ChrSpace, ChrTab,
                                  ChrBslash, ChrBs, ChrFf, 8'hFF, ChrCr, ChrLf};
  logic [7:0] json_text [$]   = '{ChrLowA, ChrColon, ChrLf, 8'h80, 8'h7F, ChrBslash, ChrColon,
                                  ChrLowZ, ChrLf};

  header_text_json_escaper_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_char_i    (in_char_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .last_of_run_o(last_of_run_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  hje_escape_checker #(.ModeAddr(RegModeAddr)) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_char_i    (in_char_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_i   (out_char_o),
    .last_of_run_i(last_of_run_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .pending_o    (pending),
    .fail_cnt_o   (fail_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) words_out <= words_out + 1;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("tb_header_text_json_escaper_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? ChrSpace : ChrTab;
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(ChrLowA, ChrLowZ));
    if (r < 70) return 8'($urandom_range(ChrDigit0, ChrDigit9));
    if (r < 76) return ChrQuote;
    if (r < 82) return ChrBslash;
    if (r < 85) return ChrBs;
    if (r < 88) return ChrFf;
    if (r < 92) return ChrTab;
    if (r < 95) return ChrSpace;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_word(input logic [7:0] ch);
    int gap;
    in_valid_i <= 1'b1;
    in_char_i  <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_in++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // mostly well-formed lines; some noise, some with colon or newline missing
  task automatic send_header_line();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) send_word(pick_blank());
    n = $urandom_range(1, 6);
    repeat (n) send_word(pick_text_byte());
    if ($urandom_range(0, 3) == 0) send_word(pick_blank());
    if (kind >= 18) send_word(ChrColon);
    if ($urandom_range(0, 1) == 0) send_word(pick_blank());
    n = $urandom_range(0, 8);
    repeat (n) send_word(pick_text_byte());
    if ($urandom_range(0, 2) == 0) send_word(ChrCr);
    if (kind < 94) send_word(ChrLf);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RegModeAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(input logic json);
    logic [31:0] v;
    v    = $urandom();
    v[0] = json;
    wait_drained();
    apb_access(1'b1, v);
    apb_access(1'b0, '0);
    mode_writes++;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    while (rx_hold_req || !rst_ni) begin
      rst_ni <= 1'b1;
      @(posedge clk_i);
    end
    forever begin
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_eager) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat (pick_stall()) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned target;
    repeat (6) @(posedge clk_i);
    apb_access(1'b0, '0);
    foreach (pretty_text[i]) send_word(pretty_text[i]);
    set_mode(1'b1);
    foreach (json_text[i]) send_word(json_text[i]);

    for (int p = 0; p < NumPhases; p++) begin
      set_mode((p == 2) ? 1'b0 : 1'($urandom_range(0, 1)));
      rx_eager   = (p == 3);
      tx_gapless = (p == 4);
      if (p == 2) begin
        // hold the output and keep pushing separator-heavy words
        rx_hold_req = 1'b1;
        tx_gapless  = 1'b1;
        repeat (6) begin
          send_word(ChrLowA);
          send_word(ChrColon);
          send_word(ChrQuote);
          send_word(ChrLf);
        end
        tx_gapless = 1'b0;
      end
      target = words_in + PhaseWords;
      while (words_in < target) send_header_line();
    end
    rx_eager = 1'b0;
    wait_drained();

    $display("run covered %0d input words and %0d output words over %0d mode writes,",
             words_in, words_out, mode_writes);
    $display("with random stalls on both sides and one long output hold");
    if (fail_cnt == 0) begin
      $display("tb_header_text_json_escaper_top: clean");
    end else begin
      $display("tb_header_text_json_escaper_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hje_pkg.sv
rtl/hje_front.sv
rtl/hje_queue.sv
rtl/hje_back.sv
rtl/header_text_json_escaper_top.sv
verif/hje_escape_checker.sv
verif/tb_header_text_json_escaper_top.sv
